FILE: hw/rtl/bucketed_sliding_window_counter_defines.svh
// Assertion macros shared by the sliding-window counter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef BUCKETED_SLIDING_WINDOW_COUNTER_DEFINES_SVH
`define BUCKETED_SLIDING_WINDOW_COUNTER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define BSWC_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define BSWC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hw/rtl/bswc_pkg.sv
// Types and fixed constants for the bucketed sliding-window counter.
// No dependencies; used by the top level.
package bswc_pkg;

    localparam int CFG_W     = 7;
    localparam int EVENTS_W  = 16;
    localparam int ELAPSED_W = 16;
    localparam int TOTAL_W   = 32;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [EVENTS_W-1:0]  events;
        logic [ELAPSED_W-1:0] elapsed;
    } bswc_in_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               flushed;
    } bswc_out_t;

endpackage

FILE: hw/rtl/bswc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bswc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/bucketed_sliding_window_counter.sv
// Channel   | Dir | Handshake          | Payload
// s_ (item) | in  | s_valid / s_ready  | bswc_in_t  {cmd, events, elapsed}
// m_ (res)  | out | m_valid / m_ready  | bswc_out_t {total, flushed}
// cfg       | in  | cfg_we             | cfg_wdata (window length)
//
// One item at a time. Clear or full flush goes straight to the result state. An update
// with elapsed e below the window length does one read-modify-write of the bucket
// RAM per elapsed unit plus one for the newest bucket, then loads its result.
// Reset or wipe needs no RAM pass: a fill count marks which buckets were written.
// A result waiting on m_ready holds in the output register; the block is free to
// take the next item, and stalls only when a second result is ready to load.
// Depends on bswc_pkg, bswc_ram and the assertion macro header.
`include "bucketed_sliding_window_counter_defines.svh"

module bucketed_sliding_window_counter #(
    parameter int MAX_BINS    = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  bswc_pkg::bswc_in_t       s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output bswc_pkg::bswc_out_t      m_data,
    input  logic                     cfg_we,
    input  logic [bswc_pkg::CFG_W-1:0] cfg_wdata
);
    import bswc_pkg::*;

    localparam int IDX_W   = $clog2(MAX_BINS);
    localparam int LEN_W   = $clog2(MAX_BINS + 1);
    localparam int NXT_W   = LEN_W + 1;
    localparam int CMP_W   = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int WIN_RST = (MAX_BINS < 64) ? MAX_BINS : 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_RD,
        ST_STEP_WB,
        ST_HEAD_RD,
        ST_HEAD_WB,
        ST_DONE
    } state_t;

    state_t                  state_reg,   state_next;
    logic [LEN_W-1:0]        win_reg,     win_next;
    logic [IDX_W-1:0]        newest_reg,  newest_next;
    logic [IDX_W-1:0]        oldest_reg,  oldest_next;
    logic [LEN_W-1:0]        fill_reg,    fill_next;
    logic                    top_vld_reg, top_vld_next;
    logic [COUNT_WIDTH-1:0]  total_reg,   total_next;
    logic [IDX_W-1:0]        remain_reg,  remain_next;
    logic [EVENTS_W-1:0]     events_reg,  events_next;
    logic                    flushed_reg, flushed_next;
    logic                    m_valid_reg, m_valid_next;
    bswc_out_t               m_data_reg,  m_data_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [COUNT_WIDTH-1:0]  ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [COUNT_WIDTH-1:0]  ram_rdata;

    logic [CMP_W-1:0]        cfg_ext;
    logic [LEN_W-1:0]        win_cfg;
    logic [IDX_W-1:0]        win_top;
    logic [IDX_W-1:0]        newest_adv;
    logic [IDX_W-1:0]        oldest_adv;
    logic [COUNT_WIDTH-1:0]  bucket_val;

    function automatic logic [IDX_W-1:0] ring_next(
        input logic [IDX_W-1:0] p,
        input logic [LEN_W-1:0] w
    );
        logic [NXT_W-1:0] inc;
        inc = NXT_W'(p) + NXT_W'(1);
        ring_next = (inc >= NXT_W'(w)) ? '0 : IDX_W'(inc);
    endfunction

    bswc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BINS)
    ) u_bucket_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Window length write, clamped to 1..MAX_BINS
    always_comb begin
        cfg_ext = CMP_W'(cfg_wdata);
        if (cfg_ext == '0) begin
            win_cfg = LEN_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_BINS)) begin
            win_cfg = LEN_W'(MAX_BINS);
        end else begin
            win_cfg = LEN_W'(cfg_ext);
        end
    end

    assign win_top    = IDX_W'(win_reg - LEN_W'(1));
    assign newest_adv = ring_next(newest_reg, win_reg);
    assign oldest_adv = ring_next(oldest_reg, win_reg);

    // Buckets below the fill count, and the top bucket once written, hold real data;
    // anything else is stale from before the last wipe and reads as zero.
    always_comb begin
        logic [IDX_W-1:0] addr;
        addr = (state_reg == ST_HEAD_WB) ? newest_reg : oldest_reg;
        if ((LEN_W'(addr) < fill_reg) || (top_vld_reg && addr == win_top)) begin
            bucket_val = ram_rdata;
        end else begin
            bucket_val = '0;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !cfg_we;

    always_comb begin
        state_next   = state_reg;
        win_next     = win_reg;
        newest_next  = newest_reg;
        oldest_next  = oldest_reg;
        fill_next    = fill_reg;
        top_vld_next = top_vld_reg;
        total_next   = total_reg;
        remain_next  = remain_reg;
        events_next  = events_reg;
        flushed_next = flushed_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = oldest_reg;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = oldest_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_we) begin
                    win_next     = win_cfg;
                    newest_next  = IDX_W'(win_cfg - LEN_W'(1));
                    oldest_next  = '0;
                    fill_next    = '0;
                    top_vld_next = 1'b0;
                    total_next   = '0;
                end else if (s_valid) begin
                    events_next  = s_data.events;
                    flushed_next = 1'b0;
                    if (s_data.cmd == CMD_CLEAR) begin
                        newest_next  = win_top;
                        oldest_next  = '0;
                        fill_next    = '0;
                        top_vld_next = 1'b0;
                        total_next   = '0;
                        flushed_next = 1'b1;
                        state_next   = ST_DONE;
                    end else if (s_data.elapsed >= ELAPSED_W'(win_reg)) begin
                        // full flush: only the newest bucket keeps data
                        newest_next  = win_top;
                        oldest_next  = '0;
                        fill_next    = '0;
                        top_vld_next = 1'b1;
                        total_next   = COUNT_WIDTH'(s_data.events);
                        ram_we       = 1'b1;
                        ram_waddr    = win_top;
                        ram_wdata    = COUNT_WIDTH'(s_data.events);
                        flushed_next = 1'b1;
                        state_next   = ST_DONE;
                    end else if (s_data.elapsed == '0) begin
                        state_next = ST_HEAD_RD;
                    end else begin
                        remain_next = IDX_W'(s_data.elapsed);
                        state_next  = ST_STEP_RD;
                    end
                end
            end
            ST_STEP_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = oldest_reg;
                state_next = ST_STEP_WB;
            end
            ST_STEP_WB: begin
                // retire the oldest bucket and advance the ring
                total_next  = total_reg - bucket_val;
                ram_we      = 1'b1;
                ram_waddr   = oldest_reg;
                ram_wdata   = '0;
                if (oldest_reg == win_top) begin
                    top_vld_next = 1'b1;
                end
                if (fill_reg != win_reg) begin
                    fill_next = fill_reg + LEN_W'(1);
                end
                oldest_next = oldest_adv;
                newest_next = newest_adv;
                remain_next = remain_reg - IDX_W'(1);
                state_next  = (remain_reg == IDX_W'(1)) ? ST_HEAD_RD : ST_STEP_RD;
            end
            ST_HEAD_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = newest_reg;
                state_next = ST_HEAD_WB;
            end
            ST_HEAD_WB: begin
                ram_we     = 1'b1;
                ram_waddr  = newest_reg;
                ram_wdata  = bucket_val + COUNT_WIDTH'(events_reg);
                total_next = total_reg + COUNT_WIDTH'(events_reg);
                if (newest_reg == win_top) begin
                    top_vld_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.total   = TOTAL_W'(total_reg);
                    m_data_next.flushed = flushed_reg;
                    m_valid_next        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        remain_reg  <= remain_next;
        events_reg  <= events_next;
        flushed_reg <= flushed_next;
        m_data_reg  <= m_data_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            win_reg     <= LEN_W'(WIN_RST);
            newest_reg  <= IDX_W'(WIN_RST - 1);
            oldest_reg  <= '0;
            fill_reg    <= '0;
            top_vld_reg <= 1'b0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            win_reg     <= win_next;
            newest_reg  <= newest_next;
            oldest_reg  <= oldest_next;
            fill_reg    <= fill_next;
            top_vld_reg <= top_vld_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // oldest bucket always sits one step past the newest on the ring
    `BSWC_ASSERT_ALWAYS(a_ring_ptrs, aclk, aresetn, oldest_reg == newest_adv)
    // fill count bounded by the window
    `BSWC_ASSERT_ALWAYS(a_fill_win, aclk, aresetn, fill_reg <= win_reg)
    // window in 1..MAX_BINS
    `BSWC_ASSERT_ALWAYS(a_win_ok, aclk, aresetn, win_reg != '0 && (win_reg <= LEN_W'(MAX_BINS)))
    // one item in flight: no back-to-back transfer on the input
    `BSWC_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

FILE: bench/tb_bucketed_sliding_window_counter.sv
// Testbench for bucketed_sliding_window_counter: directed table, a bucket aging run,
// then random phases over several window lengths, checked against a local model.
// Depends on bswc_pkg and the counter RTL.
`timescale 1ns / 100ps

module tb_bucketed_sliding_window_counter;
    import bswc_pkg::*;

    localparam int BINS        = 64;
    localparam int RAND_ITEMS  = 1300;
    localparam int HOLD_CYCLES = 400;
    localparam int WRAP_ITEMS  = 16;

    typedef enum logic {ROW_ITEM, ROW_WIN} row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic                 cmd;
        logic [EVENTS_W-1:0]  events;
        logic [ELAPSED_W-1:0] elapsed;
        logic [CFG_W-1:0]     win;
        logic                 typed;
        logic [TOTAL_W-1:0]   exp_total;
        logic                 exp_flushed;
    } dir_row_t;

    localparam int DIR_ROWS = 30;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // window length 64 out of reset
        '{ROW_ITEM, CMD_UPDATE, 16'd0,      16'd0,      7'd0,   1'b1, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'hFFFF,   16'd0,      7'd0,   1'b1, 32'd65535,  1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'hFFFF,   16'd0,      7'd0,   1'b1, 32'd131070, 1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd1,      16'd1,      7'd0,   1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd7,      16'd63,     7'd0,   1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd5,      16'd64,     7'd0,   1'b1, 32'd5,      1'b1},
        '{ROW_ITEM, CMD_UPDATE, 16'd0,      16'hFFFF,   7'd0,   1'b1, 32'd0,      1'b1},
        '{ROW_ITEM, CMD_UPDATE, 16'hAAAA,   16'd0,      7'd0,   1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_CLEAR,  16'hFFFF,   16'hFFFF,   7'd0,   1'b1, 32'd0,      1'b1},
        '{ROW_ITEM, CMD_UPDATE, 16'hFFFF,   16'd1,      7'd0,   1'b0, 32'd0,      1'b0},
        // zero clamps up to a single bucket
        '{ROW_WIN,  CMD_UPDATE, 16'd0,      16'd0,      7'd0,   1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd100,    16'd0,      7'd0,   1'b1, 32'd100,    1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd200,    16'd0,      7'd0,   1'b1, 32'd300,    1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd9,      16'd1,      7'd0,   1'b1, 32'd9,      1'b1},
        // all ones clamps down to the full ring
        '{ROW_WIN,  CMD_UPDATE, 16'd0,      16'd0,      7'd127, 1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd42,     16'd0,      7'd0,   1'b1, 32'd42,     1'b0},
        '{ROW_WIN,  CMD_UPDATE, 16'd0,      16'd0,      7'd2,   1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd10,     16'd0,      7'd0,   1'b1, 32'd10,     1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd20,     16'd1,      7'd0,   1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd30,     16'd1,      7'd0,   1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd1,      16'd2,      7'd0,   1'b1, 32'd1,      1'b1},
        '{ROW_ITEM, CMD_CLEAR,  16'd0,      16'd0,      7'd0,   1'b1, 32'd0,      1'b1},
        '{ROW_WIN,  CMD_UPDATE, 16'd0,      16'd0,      7'd65,  1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'hFFFF,   16'hFFFE,   7'd0,   1'b1, 32'd65535,  1'b1},
        '{ROW_ITEM, CMD_UPDATE, 16'h5555,   16'h5555,   7'd0,   1'b0, 32'd0,      1'b0},
        '{ROW_WIN,  CMD_UPDATE, 16'd0,      16'd0,      7'd33,  1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd3,      16'd32,     7'd0,   1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd0,      16'hAAAA,   7'd0,   1'b0, 32'd0,      1'b0},
        '{ROW_ITEM, CMD_UPDATE, 16'd4,      16'd33,     7'd0,   1'b1, 32'd4,      1'b1},
        '{ROW_ITEM, CMD_UPDATE, 16'd1,      16'd32,     7'd0,   1'b0, 32'd0,      1'b0}
    };

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    bswc_in_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    bswc_out_t        m_data;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // model state
    logic [TOTAL_W-1:0] bin_count [BINS];
    int unsigned        head_idx;
    int unsigned        tail_idx;
    int unsigned        win_len;
    logic [TOTAL_W-1:0] run_total;

    bswc_out_t   pending_totals [$];
    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;
    int unsigned hold_asked     = 0;

    bucketed_sliding_window_counter #(
        .MAX_BINS    (BINS),
        .COUNT_WIDTH (TOTAL_W)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void wipe_bins();
        for (int i = 0; i < BINS; i++) begin
            bin_count[i] = '0;
        end
        run_total = '0;
        head_idx  = win_len - 1;
        tail_idx  = 0;
    endfunction

    function automatic int unsigned step_idx(input int unsigned p);
        return (p + 1 >= win_len) ? 0 : p + 1;
    endfunction

    function automatic void apply_window_len(input logic [CFG_W-1:0] val);
        if (val == 0) begin
            win_len = 1;
        end else if (val > BINS) begin
            win_len = BINS;
        end else begin
            win_len = val;
        end
        wipe_bins();
    endfunction

    function automatic bswc_out_t count_window(input bswc_in_t it);
        bswc_out_t res;
        res.flushed = 1'b0;
        if (it.cmd == CMD_CLEAR) begin
            wipe_bins();
            res.flushed = 1'b1;
        end else if (it.elapsed >= win_len) begin
            wipe_bins();
            bin_count[head_idx] = TOTAL_W'(it.events);
            run_total           = TOTAL_W'(it.events);
            res.flushed         = 1'b1;
        end else begin
            // retire one bucket per elapsed unit, then land the events in the newest
            for (int i = 0; i < int'(it.elapsed); i++) begin
                run_total          -= bin_count[tail_idx];
                bin_count[tail_idx] = '0;
                tail_idx            = step_idx(tail_idx);
                head_idx            = step_idx(head_idx);
            end
            bin_count[head_idx] += TOTAL_W'(it.events);
            run_total           += TOTAL_W'(it.events);
        end
        res.total = run_total;
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // scoreboard: every result transfer against the oldest pending expectation
    always @(posedge aclk) begin : result_check
        bswc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_totals.size() == 0) begin
                note_mismatch($sformatf("unexpected result total=%0d flushed=%0b",
                                        m_data.total, m_data.flushed));
            end else begin
                want = pending_totals.pop_front();
                if (m_data.total !== want.total) begin
                    note_mismatch($sformatf("total %0d, expected %0d",
                                            m_data.total, want.total));
                end
                if (m_data.flushed !== want.flushed) begin
                    note_mismatch($sformatf("flushed %0b, expected %0b",
                                            m_data.flushed, want.flushed));
                end
            end
        end
    end

    // receiver: random ready pattern, plus a long hold-off on request
    initial begin : rx_pattern
        int unsigned holds_done;
        int unsigned bit_pos;
        logic [15:0] pat;
        holds_done = 0;
        bit_pos    = 0;
        pat        = '1;
        forever begin
            @(posedge aclk);
            if (hold_asked != holds_done) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                if (bit_pos == 0) begin
                    pat = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
                end
                m_ready <= pat[bit_pos];
                bit_pos  = (bit_pos + 1) % 16;
            end
        end
    end

    task automatic send_item(input bswc_in_t it, input bit use_typed = 1'b0,
                             input bswc_out_t typed_res = '0);
        bswc_out_t pred;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = count_window(it);
        pending_totals.push_back(use_typed ? typed_res : pred);
    endtask

    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        apply_window_len(val);
        @(posedge aclk);
    endtask

    function automatic logic [CFG_W-1:0] pick_window();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 5)  return '0;
        if (p < 15) return CFG_W'(1);
        if (p < 40) return CFG_W'($urandom_range(2, 4));
        if (p < 70) return CFG_W'($urandom_range(5, 12));
        if (p < 88) return CFG_W'($urandom_range(13, BINS));
        return CFG_W'($urandom_range(BINS + 1, 127));
    endfunction

    function automatic bswc_in_t rand_item();
        bswc_in_t    it;
        int unsigned p;
        int unsigned q;
        int unsigned short_max;
        p = $urandom_range(99);
        q = $urandom_range(99);
        it.cmd = CMD_UPDATE;
        if (q < 10)      it.events = '0;
        else if (q < 20) it.events = '1;
        else if (q < 60) it.events = EVENTS_W'($urandom_range(0, 255));
        else             it.events = EVENTS_W'($urandom_range(0, 65535));
        short_max = (win_len - 1 < 3) ? win_len - 1 : 3;
        if (p < 5) begin
            it.cmd     = CMD_CLEAR;
            it.elapsed = ELAPSED_W'($urandom_range(0, 65535));
        end else if (p < 15) begin
            it.elapsed = ELAPSED_W'(win_len + $urandom_range(0, 3));
        end else if (p < 20) begin
            it.elapsed = ELAPSED_W'($urandom_range(0, 65535));
        end else if (p < 60) begin
            it.elapsed = ELAPSED_W'($urandom_range(0, short_max));
        end else begin
            it.elapsed = ELAPSED_W'($urandom_range(0, win_len - 1));
        end
        return it;
    endfunction

    initial begin : stimulus
        bswc_in_t    it;
        bswc_out_t   want;
        int unsigned rand_sent;
        int unsigned phase_no;
        int unsigned n;

        win_len = BINS;
        wipe_bins();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].kind == ROW_WIN) begin
                write_window(DIR_TABLE[r].win);
            end else begin
                it.cmd       = DIR_TABLE[r].cmd;
                it.events    = DIR_TABLE[r].events;
                it.elapsed   = DIR_TABLE[r].elapsed;
                want.total   = DIR_TABLE[r].exp_total;
                want.flushed = DIR_TABLE[r].exp_flushed;
                send_item(it, DIR_TABLE[r].typed, want);
                pace_sender();
            end
        end

        // pile max events into one bucket back to back, then age it out of the ring
        write_window(CFG_W'(BINS));
        it.cmd     = CMD_UPDATE;
        it.events  = '1;
        it.elapsed = '0;
        for (int k = 0; k < WRAP_ITEMS; k++) begin
            send_item(it);
        end
        it.events  = '0;
        it.elapsed = ELAPSED_W'(BINS - 1);
        send_item(it);
        it.elapsed = ELAPSED_W'(1);
        send_item(it);

        rand_sent = 0;
        phase_no  = 0;
        while (rand_sent < RAND_ITEMS) begin
            write_window(pick_window());
            n = $urandom_range(40, 160);
            for (int k = 0; k < n; k++) begin
                if (phase_no == 2 && k == 10) begin
                    hold_asked <= hold_asked + 1;
                end
                send_item(rand_item());
                rand_sent++;
                // every fourth phase runs back to back
                if (phase_no % 4 != 3) pace_sender();
            end
            phase_no++;
        end

        s_valid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bswc_pkg.sv
hw/rtl/bswc_ram.sv
hw/rtl/bucketed_sliding_window_counter.sv
bench/tb_bucketed_sliding_window_counter.sv
